// ===== src/lzw_pkg.sv =====
// Shared types and constants for the LZW decoder.
// Used by every module of the block; depends on nothing.
package lzw_pkg;

  // Fixed field widths
  localparam int CODE_W = 12;
  localparam int LEN_W  = 7;

  // Defaults for the top-level parameters
  localparam int DICT_DEPTH_DEF = 4096;
  localparam int MAX_STRING_DEF = 64;

  // Number of single-byte codes preset in the dictionary
  localparam int BASE_CODES = 256;

  // Saturation value of a stored string length
  localparam logic [LEN_W-1:0] LEN_SAT = 7'd127;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CODE = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // One dictionary entry
  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        tail;
    logic [7:0]        head;
    logic [LEN_W-1:0]  len;
  } dict_entry_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RDP,
    S_RDC,
    S_WR,
    S_RDL,
    S_LEN,
    S_WALK,
    S_EMIT,
    S_ERR
  } state_e;

endpackage

// ===== src/lzw_dict.sv =====
// Dictionary memory: one write port, one registered read port.
// Entries below the base code count read as their preset single-byte value.
// Depends on lzw_pkg.
module lzw_dict #(
  parameter int DICT_DEPTH = lzw_pkg::DICT_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic [$clog2(DICT_DEPTH)-1:0] rd_addr_i,
  input  logic                    wr_en_i,
  input  logic [$clog2(DICT_DEPTH)-1:0] wr_addr_i,
  input  lzw_pkg::dict_entry_t    wr_entry_i,
  output lzw_pkg::dict_entry_t    rd_entry_o
);

  localparam int AW = $clog2(DICT_DEPTH);

  lzw_pkg::dict_entry_t mem_q [DICT_DEPTH];
  lzw_pkg::dict_entry_t rd_q;
  logic                 rd_base_q;
  logic [7:0]           rd_low_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  // Registered read, plus the preset flag of the address
  always_ff @(posedge clk_i) begin
    rd_q      <= mem_q[rd_addr_i];
    rd_base_q <= (rd_addr_i < AW'(lzw_pkg::BASE_CODES));
    rd_low_q  <= rd_addr_i[7:0];
  end

  // Substitute the preset value for base codes
  always_comb begin
    if (rd_base_q) begin
      rd_entry_o.prefix = '0;
      rd_entry_o.tail   = rd_low_q;
      rd_entry_o.head   = rd_low_q;
      rd_entry_o.len    = lzw_pkg::LEN_W'(1);
    end else begin
      rd_entry_o = rd_q;
    end
  end

endmodule

// ===== src/lzw_stack.sv =====
// Byte stack that reverses a prefix-chain walk into string order.
// Simple dual-port memory with registered read; takes its default depth from lzw_pkg.
module lzw_stack #(
  parameter int MAX_STRING = lzw_pkg::MAX_STRING_DEF
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(MAX_STRING)-1:0] wr_addr_i,
  input  logic [7:0]                    wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(MAX_STRING)-1:0] rd_addr_i,
  output logic [7:0]                    rd_data_o
);

  logic [7:0] mem_q [MAX_STRING];
  logic [7:0] rd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, held while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== src/lzw_seq.sv =====
// Sequencer of the LZW decoder: code checks, dictionary update, chain walk
// and byte emission, all through the single dictionary read port.
// Depends on lzw_pkg; drives lzw_dict and lzw_stack.
module lzw_seq #(
  parameter int DICT_DEPTH = lzw_pkg::DICT_DEPTH_DEF,
  parameter int MAX_STRING = lzw_pkg::MAX_STRING_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lzw_pkg::CODE_W-1:0]    code_i,
  output logic [$clog2(DICT_DEPTH)-1:0] dict_rd_addr_o,
  output logic                          dict_wr_en_o,
  output logic [$clog2(DICT_DEPTH)-1:0] dict_wr_addr_o,
  output lzw_pkg::dict_entry_t          dict_wr_entry_o,
  input  lzw_pkg::dict_entry_t          dict_rd_entry_i,
  output logic                          stk_wr_en_o,
  output logic [$clog2(MAX_STRING)-1:0] stk_wr_addr_o,
  output logic [7:0]                    stk_wr_data_o,
  output logic                          stk_rd_en_o,
  output logic [$clog2(MAX_STRING)-1:0] stk_rd_addr_o,
  input  logic [7:0]                    stk_rd_data_i,
  input  logic                          out_free_i,
  output logic                          item_vld_o,
  output lzw_pkg::out_item_t            item_o
);

  localparam int AW    = $clog2(DICT_DEPTH);
  localparam int SW    = $clog2(MAX_STRING);
  localparam int NFW   = AW + 1;
  localparam int CW    = lzw_pkg::CODE_W;
  localparam int LW    = lzw_pkg::LEN_W;
  localparam int CMPW  = (NFW > CW) ? NFW : CW;

  lzw_pkg::state_e state_q, state_d;

  logic [NFW-1:0] nf_q;
  logic [CW-1:0]  prev_q;
  logic           have_q;
  logic [CW-1:0]  code_q;
  logic           eqnf_q;
  logic [7:0]     phead_q;
  logic [LW-1:0]  plen_q;
  logic [LW-1:0]  len_q;
  logic [SW-1:0]  wi_q;
  logic [LW-1:0]  j_q;
  logic           sv_q;
  logic           rlast_q;
  logic [1:0]     err_q;

  logic accept;
  logic err_code;
  logic add_entry;
  logic err_len;
  logic load;
  logic issue;

  // Code checks against the fill count at acceptance
  always_comb begin
    err_code = (CMPW'(code_i) > CMPW'(nf_q)) ||
               (CMPW'(code_i) >= CMPW'(DICT_DEPTH)) ||
               ((CMPW'(code_i) == CMPW'(nf_q)) && !have_q);
    add_entry = have_q && (nf_q < NFW'(DICT_DEPTH)) &&
                (CMPW'(prev_q) < CMPW'(nf_q));
    err_len = (dict_rd_entry_i.len > LW'(MAX_STRING)) || (dict_rd_entry_i.len == '0);
  end

  assign accept = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lzw_pkg::S_IDLE: begin
        if (accept) begin
          if (err_code)       state_d = lzw_pkg::S_ERR;
          else if (add_entry) state_d = lzw_pkg::S_RDP;
          else                state_d = lzw_pkg::S_RDL;
        end
      end
      lzw_pkg::S_RDP:  state_d = lzw_pkg::S_RDC;
      lzw_pkg::S_RDC:  state_d = lzw_pkg::S_WR;
      lzw_pkg::S_WR:   state_d = lzw_pkg::S_RDL;
      lzw_pkg::S_RDL:  state_d = lzw_pkg::S_LEN;
      lzw_pkg::S_LEN:  state_d = err_len ? lzw_pkg::S_ERR : lzw_pkg::S_WALK;
      lzw_pkg::S_WALK: begin
        if (wi_q == '0) state_d = lzw_pkg::S_EMIT;
      end
      lzw_pkg::S_EMIT: begin
        if (load && rlast_q) state_d = lzw_pkg::S_IDLE;
      end
      lzw_pkg::S_ERR: begin
        if (out_free_i) state_d = lzw_pkg::S_IDLE;
      end
      default: state_d = lzw_pkg::S_IDLE;
    endcase
  end

  // Outputs and port controls
  always_comb begin
    in_ready_o      = 1'b0;
    dict_rd_addr_o  = AW'(code_q);
    dict_wr_en_o    = 1'b0;
    dict_wr_addr_o  = nf_q[AW-1:0];
    dict_wr_entry_o.prefix = prev_q;
    dict_wr_entry_o.tail   = eqnf_q ? phead_q : dict_rd_entry_i.head;
    dict_wr_entry_o.head   = phead_q;
    dict_wr_entry_o.len    = (plen_q == lzw_pkg::LEN_SAT) ? lzw_pkg::LEN_SAT
                                                          : plen_q + LW'(1);
    stk_wr_en_o     = 1'b0;
    stk_wr_addr_o   = wi_q;
    stk_wr_data_o   = dict_rd_entry_i.tail;
    stk_rd_addr_o   = j_q[SW-1:0];
    load            = 1'b0;
    issue           = 1'b0;
    item_vld_o      = 1'b0;
    item_o.data     = stk_rd_data_i;
    item_o.last     = rlast_q;
    item_o.status   = lzw_pkg::ST_OK;
    unique case (state_q)
      lzw_pkg::S_IDLE: in_ready_o = 1'b1;
      lzw_pkg::S_RDP:  dict_rd_addr_o = AW'(prev_q);
      lzw_pkg::S_RDC:  dict_rd_addr_o = AW'(code_q);
      lzw_pkg::S_WR:   dict_wr_en_o = 1'b1;
      lzw_pkg::S_RDL:  dict_rd_addr_o = AW'(code_q);
      lzw_pkg::S_LEN:  dict_rd_addr_o = AW'(code_q);
      lzw_pkg::S_WALK: begin
        stk_wr_en_o    = 1'b1;
        dict_rd_addr_o = AW'(dict_rd_entry_i.prefix);
      end
      lzw_pkg::S_EMIT: begin
        load       = sv_q && out_free_i;
        issue      = (j_q < len_q) && (!sv_q || load);
        item_vld_o = load;
      end
      lzw_pkg::S_ERR: begin
        item_vld_o    = out_free_i;
        item_o.data   = '0;
        item_o.last   = 1'b1;
        item_o.status = err_q;
      end
      default: ;
    endcase
    stk_rd_en_o = issue;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzw_pkg::S_IDLE;
      nf_q    <= NFW'(lzw_pkg::BASE_CODES);
      prev_q  <= '0;
      have_q  <= 1'b0;
      wi_q    <= '0;
      j_q     <= '0;
      sv_q    <= 1'b0;
      rlast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Advance the fill count on each new entry
      if (state_q == lzw_pkg::S_WR) begin
        nf_q <= nf_q + NFW'(1);
      end
      // Take the code as previous once it passed the range checks
      if (state_q == lzw_pkg::S_RDL) begin
        prev_q <= code_q;
        have_q <= 1'b1;
      end
      // Walk index: start at the last stack slot, step down
      if (state_q == lzw_pkg::S_LEN) begin
        wi_q <= SW'(dict_rd_entry_i.len - LW'(1));
      end else if (state_q == lzw_pkg::S_WALK) begin
        wi_q <= wi_q - SW'(1);
      end
      // Emission read pointer and pending-data flag
      if (state_q == lzw_pkg::S_LEN) begin
        j_q  <= '0;
        sv_q <= 1'b0;
      end else if (state_q == lzw_pkg::S_EMIT) begin
        if (issue) begin
          j_q     <= j_q + LW'(1);
          rlast_q <= (j_q == len_q - LW'(1));
        end
        sv_q <= issue || (sv_q && !load);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q <= code_i;
      eqnf_q <= (CMPW'(code_i) == CMPW'(nf_q));
      err_q  <= lzw_pkg::ST_BAD_CODE;
    end
    if (state_q == lzw_pkg::S_RDC) begin
      phead_q <= dict_rd_entry_i.head;
      plen_q  <= dict_rd_entry_i.len;
    end
    if (state_q == lzw_pkg::S_LEN) begin
      len_q <= dict_rd_entry_i.len;
      err_q <= lzw_pkg::ST_TOO_LONG;
    end
  end

  // A new entry is only written while the table has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lzw_pkg::S_WR) |-> (nf_q < NFW'(DICT_DEPTH)))
    else $error("dictionary write beyond depth");

  // The fill count never moves backward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lzw_pkg::S_IDLE) |=> (nf_q >= $past(nf_q)))
    else $error("fill count decreased");

  // The previous code always names an existing entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (have_q && state_q == lzw_pkg::S_IDLE) |-> (CMPW'(prev_q) < CMPW'(nf_q)))
    else $error("previous code not in dictionary");

  // The walk only runs on a string that fits the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lzw_pkg::S_WALK) |-> (len_q != '0 && len_q <= LW'(MAX_STRING)))
    else $error("walk on bad string length");

  // The final byte of a string returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_o && item_o.last) |=> (state_q == lzw_pkg::S_IDLE))
    else $error("sequencer busy after final byte");

endmodule

// ===== src/lzw_decoder.sv =====
// LZW decoder, 12-bit codes. A code is taken only once the last result of
// the one before is issued. A bad code yields an error result; a good one
// may first add an entry, then the prefix walk takes one dictionary read
// per byte, then the stack port emits one byte per cycle while the output
// register is free. Reset is asynchronous and needs no clearing pass: base
// entries are decoded from the address and the fill count marks valid ones.
module lzw_decoder #(
  parameter int DICT_DEPTH = lzw_pkg::DICT_DEPTH_DEF,
  parameter int MAX_STRING = lzw_pkg::MAX_STRING_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [lzw_pkg::CODE_W-1:0] code_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_o,
  output logic [1:0]                 status_o
);

  localparam int AW = $clog2(DICT_DEPTH);
  localparam int SW = $clog2(MAX_STRING);

  logic [AW-1:0]        dict_rd_addr;
  logic                 dict_wr_en;
  logic [AW-1:0]        dict_wr_addr;
  lzw_pkg::dict_entry_t dict_wr_entry;
  lzw_pkg::dict_entry_t dict_rd_entry;
  logic                 stk_wr_en;
  logic [SW-1:0]        stk_wr_addr;
  logic [7:0]           stk_wr_data;
  logic                 stk_rd_en;
  logic [SW-1:0]        stk_rd_addr;
  logic [7:0]           stk_rd_data;
  logic                 out_free;
  logic                 item_vld;
  lzw_pkg::out_item_t   item;
  logic                 ovalid_q;
  lzw_pkg::out_item_t   oitem_q;

  lzw_dict #(
    .DICT_DEPTH (DICT_DEPTH)
  ) u_dict (
    .clk_i      (clk_i),
    .rd_addr_i  (dict_rd_addr),
    .wr_en_i    (dict_wr_en),
    .wr_addr_i  (dict_wr_addr),
    .wr_entry_i (dict_wr_entry),
    .rd_entry_o (dict_rd_entry)
  );

  lzw_stack #(
    .MAX_STRING (MAX_STRING)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (stk_wr_en),
    .wr_addr_i (stk_wr_addr),
    .wr_data_i (stk_wr_data),
    .rd_en_i   (stk_rd_en),
    .rd_addr_i (stk_rd_addr),
    .rd_data_o (stk_rd_data)
  );

  lzw_seq #(
    .DICT_DEPTH (DICT_DEPTH),
    .MAX_STRING (MAX_STRING)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .code_i          (code_i),
    .dict_rd_addr_o  (dict_rd_addr),
    .dict_wr_en_o    (dict_wr_en),
    .dict_wr_addr_o  (dict_wr_addr),
    .dict_wr_entry_o (dict_wr_entry),
    .dict_rd_entry_i (dict_rd_entry),
    .stk_wr_en_o     (stk_wr_en),
    .stk_wr_addr_o   (stk_wr_addr),
    .stk_wr_data_o   (stk_wr_data),
    .stk_rd_en_o     (stk_rd_en),
    .stk_rd_addr_o   (stk_rd_addr),
    .stk_rd_data_i   (stk_rd_data),
    .out_free_i      (out_free),
    .item_vld_o      (item_vld),
    .item_o          (item)
  );

  // Output register: free when empty or being taken this cycle
  assign out_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (item_vld) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // Hold the result payload until the transaction completes
  always_ff @(posedge clk_i) begin
    if (item_vld) begin
      oitem_q <= item;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = oitem_q.data;
  assign last_o      = oitem_q.last;
  assign status_o    = oitem_q.status;

endmodule

// ===== dv/lzw_decoder_tb.sv =====
// Self-checking testbench for lzw_decoder: drives 12-bit codes and checks every decoded byte.
// Depends on lzw_pkg and lzw_decoder; a built-in dictionary tracker predicts each transaction.
module lzw_decoder_tb;

  // Small dictionary so that the table fills within the run
  localparam int DICT    = 512;
  localparam int MAX_STR = lzw_pkg::MAX_STRING_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 200;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // Tracks the dictionary and holds the bytes still to come, oldest first
  class decode_tracker;
    logic [lzw_pkg::CODE_W-1:0] prefix_mem [DICT];
    logic [7:0]                 tail_mem   [DICT];
    logic [7:0]                 head_mem   [DICT];
    logic [lzw_pkg::LEN_W-1:0]  len_mem    [DICT];
    logic [12:0]                next_free;
    logic [lzw_pkg::CODE_W-1:0] prev_code;
    bit                         have_prev;
    lzw_pkg::out_item_t         pending_bytes [$];
    int                         mismatches;

    function new();
      for (int i = 0; i < DICT; i++) begin
        prefix_mem[i] = '0;
        tail_mem[i]   = (i < lzw_pkg::BASE_CODES) ? i[7:0] : 8'd0;
        head_mem[i]   = (i < lzw_pkg::BASE_CODES) ? i[7:0] : 8'd0;
        len_mem[i]    = (i < lzw_pkg::BASE_CODES) ? 7'd1 : 7'd0;
      end
      next_free  = 13'(lzw_pkg::BASE_CODES);
      prev_code  = '0;
      have_prev  = 1'b0;
      mismatches = 0;
    endfunction

    function void push_result(logic [7:0] data, logic last, logic [1:0] status);
      lzw_pkg::out_item_t item;
      item.data   = data;
      item.last   = last;
      item.status = status;
      pending_bytes.push_back(item);
    endfunction

    // Expand one accepted code: grow the dictionary, then queue its bytes
    function void expand_code(logic [lzw_pkg::CODE_W-1:0] c);
      logic [7:0]                 head_byte;
      logic [lzw_pkg::CODE_W-1:0] idx;
      logic [lzw_pkg::CODE_W-1:0] k;
      logic [7:0]                 walk_buf [MAX_STR];
      int                         n;

      // Reject codes past the table, and the self reference with nothing before it
      if ({1'b0, c} > next_free || c >= DICT ||
          ({1'b0, c} == next_free && !have_prev)) begin
        push_result(8'd0, 1'b1, lzw_pkg::ST_BAD_CODE);
        return;
      end

      // Add previous string plus first byte of the current one, until the table is full
      if (have_prev && next_free < DICT) begin
        idx       = next_free[lzw_pkg::CODE_W-1:0];
        head_byte = ({1'b0, c} == next_free) ? head_mem[prev_code] : head_mem[c];
        prefix_mem[idx] = prev_code;
        tail_mem[idx]   = head_byte;
        head_mem[idx]   = head_mem[prev_code];
        len_mem[idx]    = (len_mem[prev_code] == lzw_pkg::LEN_SAT) ? lzw_pkg::LEN_SAT
                                                                   : len_mem[prev_code] + 7'd1;
        next_free++;
      end
      prev_code = c;
      have_prev = 1'b1;

      n = len_mem[c];
      if (n > MAX_STR || n == 0) begin
        push_result(8'd0, 1'b1, lzw_pkg::ST_TOO_LONG);
        return;
      end

      // Walk the prefix chain from the tail back to the head
      k = c;
      for (int i = n; i > 0; i--) begin
        walk_buf[i-1] = tail_mem[k];
        if (i > 1) k = prefix_mem[k];
      end
      for (int i = 0; i < n; i++) push_result(walk_buf[i], i == n - 1, lzw_pkg::ST_OK);
    endfunction

    // Print one line per mismatch and count it
    task report(string msg);
      mismatches++;
      $display("ERROR: %s", msg);
    endtask

    task check_byte(logic [7:0] data, logic last, logic [1:0] status);
      lzw_pkg::out_item_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("result byte %02h last %0b status %0d with nothing pending",
                         data, last, status));
        return;
      end
      want = pending_bytes.pop_front();
      if (data !== want.data)
        report($sformatf("byte %02h, want %02h", data, want.data));
      if (last !== want.last)
        report($sformatf("last %0b, want %0b (byte %02h)", last, want.last, want.data));
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
    endtask
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [lzw_pkg::CODE_W-1:0] code_i      = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [7:0]                 out_byte_o;
  logic                       last_o;
  logic [1:0]                 status_o;

  decode_tracker tracker;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  logic          rx_hold        = 1'b0;
  event          hold_go;

  lzw_decoder #(
    .DICT_DEPTH (DICT),
    .MAX_STRING (MAX_STR)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .code_i     (code_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .status_o   (status_o)
  );

  // Clock, period 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Random receiver stalls, forced low during a hold
  always @(posedge clk_i) begin
    if (!rst_ni || rx_hold) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold the receiver off for a counted stretch when asked
  initial begin
    forever begin
      @(hold_go);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  // Check each result transaction against the oldest pending byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_byte(out_byte_o, last_o, status_o);
    end
  end

  task set_idle(idle_mode_e m);
    send_idle_pct   = (m == IDLE_SEND) ? 59 : (m == IDLE_BOTH) ? 29 : 0;
    recv_stall_pct <= (m == IDLE_RECV) ? 59 : (m == IDLE_BOTH) ? 29 : 0;
  endtask

  // Offer one code, idling first at random, and wait for its transaction
  task send_code(logic [lzw_pkg::CODE_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    code_i     <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.expand_code(c);
  endtask

  // Drop valid and wait until every pending byte has come out
  task drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Pick a code, mostly well formed: known entries, self references, recent long strings
  function automatic logic [lzw_pkg::CODE_W-1:0] pick_code();
    int r;
    int nf;
    r  = $urandom_range(99);
    nf = tracker.next_free;
    if (r < 5 && nf < DICT - 1) return lzw_pkg::CODE_W'($urandom_range(DICT - 1, nf + 1));
    if (r < 30 && nf < DICT) return lzw_pkg::CODE_W'(nf);
    if (r < 50) return lzw_pkg::CODE_W'($urandom_range(nf - 1,
                       (nf > lzw_pkg::BASE_CODES + 16) ? nf - 16 : 0));
    if (r < 75) return lzw_pkg::CODE_W'($urandom_range(lzw_pkg::BASE_CODES - 1, 0));
    return lzw_pkg::CODE_W'($urandom_range(nf - 1, 0));
  endfunction

  initial begin
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad codes at start, extremes, self references, codes past the table
    set_idle(IDLE_NONE);
    send_code(lzw_pkg::CODE_W'(lzw_pkg::BASE_CODES));
    send_code(12'hFFF);
    send_code(12'h000);
    send_code(12'h0FF);
    send_code(12'h080);
    send_code(12'h001);
    repeat (3) send_code(tracker.next_free[lzw_pkg::CODE_W-1:0]);
    send_code(tracker.next_free[lzw_pkg::CODE_W-1:0] + 12'd1);
    send_code(12'h800);
    send_code(tracker.next_free[lzw_pkg::CODE_W-1:0] - 12'd1);
    send_code(lzw_pkg::CODE_W'(lzw_pkg::BASE_CODES));
    send_code(lzw_pkg::CODE_W'(lzw_pkg::BASE_CODES + 1));
    send_code(12'h000);

    // Random codes across all idle modes, with a long receiver hold and a full pause
    for (int i = 0; i < 100; i++) begin
      if (i == 40) begin
        set_idle(IDLE_NONE);
        -> hold_go;
      end else begin
        set_idle(idle_mode_e'((i / 25) % 4));
      end
      if (i == 70) drain_results();
      send_code(pick_code());
    end

    // Self-reference chain: lengths grow past the string limit and saturate
    set_idle(IDLE_BOTH);
    send_code(lzw_pkg::CODE_W'($urandom_range(lzw_pkg::BASE_CODES - 1, 0)));
    for (int i = 0; i < 140; i++) begin
      set_idle(idle_mode_e'((i / 35) % 4));
      send_code(tracker.next_free[lzw_pkg::CODE_W-1:0]);
    end

    // Fill the table with single-byte codes, then decode on a full table
    drain_results();
    for (int i = 0; tracker.next_free < DICT; i++) begin
      set_idle(idle_mode_e'((i / 500) % 4));
      send_code(lzw_pkg::CODE_W'($urandom_range(lzw_pkg::BASE_CODES - 1, 0)));
    end
    for (int i = 0; i < 190; i++) begin
      set_idle(idle_mode_e'((i / 45) % 4));
      send_code(lzw_pkg::CODE_W'($urandom_range(DICT - 1, 0)));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.pending_bytes.size() != 0)
      tracker.report($sformatf("%0d results never came", tracker.pending_bytes.size()));
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lzw_pkg.sv
src/lzw_dict.sv
src/lzw_stack.sv
src/lzw_seq.sv
src/lzw_decoder.sv
dv/lzw_decoder_tb.sv
